### rtl/fnss_pkg.sv
// ----------------------------------------------------------------------------
// fnss_pkg
// Shared types and constants of the four-neighbour sum stencil.
// ----------------------------------------------------------------------------
package fnss_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int POS_W      = 10;
  localparam int SLOT_W     = 2;
  localparam int NUM_SLOTS  = 3;

  // smallest frame dimension, also the reset value of both registers
  localparam int FRAME_DIM_MIN = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // control of one item between the address stage and the sum stage
  typedef struct packed {
    logic             emit;
    logic             left_en;
    logic             right_en;
    logic             up_en;
    logic             down_en;
    logic             first_col;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } s1_ctrl_t;

endpackage

### rtl/fnss_line_store.sv
// ----------------------------------------------------------------------------
// fnss_line_store
// Three-row line store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fnss_line_store #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [fnss_pkg::SLOT_W-1:0]         wr_slot,
  input  logic [$clog2(MAX_COLS)-1:0]         wr_col,
  input  logic [PIXEL_BITS-1:0]               wr_data,
  input  logic                                rd_en,
  input  logic [fnss_pkg::SLOT_W-1:0]         rd_slot_a,
  input  logic [$clog2(MAX_COLS)-1:0]         rd_col_a,
  input  logic [fnss_pkg::SLOT_W-1:0]         rd_slot_b,
  input  logic [$clog2(MAX_COLS)-1:0]         rd_col_b,
  output logic [PIXEL_BITS-1:0]               rd_data_a,
  output logic [PIXEL_BITS-1:0]               rd_data_b
);
  import fnss_pkg::*;

  localparam int DEPTH  = NUM_SLOTS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLS);

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                                 input logic [COL_W-1:0] col);
    addr_of = ADDR_W'(slot) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_of(wr_slot, wr_col)] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[addr_of(rd_slot_a, rd_col_a)];
      rd_data_b <= mem[addr_of(rd_slot_b, rd_col_b)];
    end
  end

endmodule

### rtl/fnss_seq.sv
// ----------------------------------------------------------------------------
// fnss_seq
// Raster position counters, slot rotation, config registers and the
// line store addresses of each item.
// ----------------------------------------------------------------------------
module fnss_seq #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [fnss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fnss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  logic                               mode,
  input  logic [PIXEL_BITS-1:0]              pixel,
  output logic                               mem_wr_en,
  output logic [fnss_pkg::SLOT_W-1:0]        mem_wr_slot,
  output logic [$clog2(MAX_COLS)-1:0]        mem_wr_col,
  output logic                               mem_rd_en,
  output logic [fnss_pkg::SLOT_W-1:0]        rd_slot_a,
  output logic [$clog2(MAX_COLS)-1:0]        rd_col_a,
  output logic [fnss_pkg::SLOT_W-1:0]        rd_slot_b,
  output logic [$clog2(MAX_COLS)-1:0]        rd_col_b,
  output logic                               s1_load,
  output fnss_pkg::s1_ctrl_t                 s1_ctrl,
  output logic [PIXEL_BITS-1:0]              col0_pix
);
  import fnss_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);

  logic [RCNT_W-1:0]     frame_rows;
  logic [CCNT_W-1:0]     frame_cols;
  logic [SLOT_W-1:0]     row_slot_base;
  logic [ROW_W-1:0]      input_row;
  logic [COL_W-1:0]      input_col;
  logic                  flush_active;
  logic [COL_W-1:0]      flush_col;
  logic [PIXEL_BITS-1:0] col0_cur;
  logic [PIXEL_BITS-1:0] col0_prev;

  logic [SLOT_W-1:0] prev_slot;
  logic [SLOT_W-1:0] prev2_slot;
  logic              is_flush;
  logic              take_pix;
  logic              take_flush;
  logic [COL_W-1:0]  col;
  logic [CCNT_W-1:0] col_inc;
  logic              right_en;
  logic [RCNT_W-1:0] row_inc;
  logic              frame_end;
  logic [ROW_W-1:0]  row_m1;
  logic [RCNT_W-1:0] rows_m1;
  logic [RCNT_W-1:0] rows_clamped;
  logic [CCNT_W-1:0] cols_clamped;

  always_comb begin
    prev_slot  = (row_slot_base == '0) ? SLOT_W'(NUM_SLOTS - 1)
                                       : row_slot_base - SLOT_W'(1);
    prev2_slot = (row_slot_base == SLOT_W'(NUM_SLOTS - 1)) ? '0
                                                           : row_slot_base + SLOT_W'(1);
    is_flush   = (mode == MODE_FLUSH);
    take_pix   = accept && !is_flush && !flush_active;
    take_flush = accept && is_flush && flush_active;
    col        = is_flush ? flush_col : input_col;
    col_inc    = CCNT_W'(col) + CCNT_W'(1);
    right_en   = (col_inc < frame_cols);
    row_inc    = RCNT_W'(input_row) + RCNT_W'(1);
    frame_end  = (row_inc >= frame_rows);
    row_m1     = input_row - ROW_W'(1);
    rows_m1    = frame_rows - RCNT_W'(1);
  end

  // saturate register writes into the legal range
  always_comb begin
    if (cfg_data < CFG_DATA_W'(FRAME_DIM_MIN)) begin
      rows_clamped = RCNT_W'(FRAME_DIM_MIN);
      cols_clamped = CCNT_W'(FRAME_DIM_MIN);
    end else begin
      rows_clamped = (32'(cfg_data) > 32'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS)
                                                     : RCNT_W'(cfg_data);
      cols_clamped = (32'(cfg_data) > 32'(MAX_COLS)) ? CCNT_W'(MAX_COLS)
                                                     : CCNT_W'(cfg_data);
    end
  end

  assign mem_wr_en   = take_pix;
  assign mem_wr_slot = row_slot_base;
  assign mem_wr_col  = input_col;
  assign s1_load     = take_pix || take_flush;
  assign mem_rd_en   = s1_load;
  assign rd_slot_a   = prev_slot;
  assign rd_col_a    = right_en ? col_inc[COL_W-1:0] : col;
  assign rd_slot_b   = prev2_slot;
  assign rd_col_b    = col;
  assign col0_pix    = col0_prev;

  always_comb begin
    s1_ctrl.emit      = is_flush || (input_row != '0);
    s1_ctrl.left_en   = (col != '0);
    s1_ctrl.right_en  = right_en;
    s1_ctrl.up_en     = is_flush || (RCNT_W'(input_row) >= RCNT_W'(2));
    s1_ctrl.down_en   = !is_flush;
    s1_ctrl.first_col = (col == '0);
    s1_ctrl.last      = is_flush && !right_en;
    s1_ctrl.row       = is_flush ? POS_W'(rows_m1) : POS_W'(row_m1);
    s1_ctrl.col       = POS_W'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows    <= RCNT_W'(FRAME_DIM_MIN);
      frame_cols    <= CCNT_W'(FRAME_DIM_MIN);
      row_slot_base <= '0;
      input_row     <= '0;
      input_col     <= '0;
      flush_active  <= 1'b0;
      flush_col     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FRAME_ROWS: frame_rows <= rows_clamped;
          REG_FRAME_COLS: frame_cols <= cols_clamped;
          default: ;
        endcase
      end
      if (take_pix) begin
        if (!right_en) begin
          input_col     <= '0;
          row_slot_base <= prev2_slot;
          if (frame_end) begin
            input_row    <= '0;
            flush_active <= 1'b1;
            flush_col    <= '0;
          end else begin
            input_row <= row_inc[ROW_W-1:0];
          end
        end else begin
          input_col <= col_inc[COL_W-1:0];
        end
      end
      if (take_flush) begin
        if (!right_en) begin
          flush_active <= 1'b0;
          flush_col    <= '0;
        end else begin
          flush_col <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  // column-0 pixel of the row above, kept out of the store read ports
  always_ff @(posedge clk) begin
    if (take_pix) begin
      if (input_col == '0) begin
        col0_cur <= pixel;
      end
      if (!right_en) begin
        col0_prev <= col0_cur;
      end
    end
  end

endmodule

### rtl/fnss_win.sv
// ----------------------------------------------------------------------------
// fnss_win
// Sum stage: left-neighbour window, four-term add and output register.
// ----------------------------------------------------------------------------
module fnss_win #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s1_load,
  input  fnss_pkg::s1_ctrl_t             s1_ctrl_in,
  input  logic signed [PIXEL_BITS-1:0]   down_in,
  input  logic signed [PIXEL_BITS-1:0]   col0_in,
  input  logic signed [PIXEL_BITS-1:0]   rd_data_a,
  input  logic signed [PIXEL_BITS-1:0]   rd_data_b,
  input  logic                           out_stall,
  output logic                           hold,
  output logic                           out_valid,
  output logic signed [PIXEL_BITS+1:0]   neighbour_sum,
  output logic [fnss_pkg::POS_W-1:0]     out_row,
  output logic [fnss_pkg::POS_W-1:0]     out_col,
  output logic                           frame_last
);
  import fnss_pkg::*;

  localparam int SUM_W = PIXEL_BITS + 2;

  logic                         s1_valid;
  s1_ctrl_t                     s1;
  logic signed [PIXEL_BITS-1:0] s1_down;
  logic signed [PIXEL_BITS-1:0] s1_col0;
  logic signed [PIXEL_BITS-1:0] win_mid;
  logic signed [PIXEL_BITS-1:0] win_left;

  logic                         s1_adv;
  logic signed [SUM_W-1:0]      t_left;
  logic signed [SUM_W-1:0]      t_right;
  logic signed [SUM_W-1:0]      t_up;
  logic signed [SUM_W-1:0]      t_down;
  logic signed [SUM_W-1:0]      sum;

  assign s1_adv = s1_valid && (!s1.emit || !out_valid || !out_stall);
  assign hold   = s1_valid && !s1_adv;

  always_comb begin
    t_left  = s1.left_en  ? SUM_W'(win_left)  : '0;
    t_right = s1.right_en ? SUM_W'(rd_data_a) : '0;
    t_up    = s1.up_en    ? SUM_W'(rd_data_b) : '0;
    t_down  = s1.down_en  ? SUM_W'(s1_down)   : '0;
    sum     = t_left + t_right + t_up + t_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1      <= s1_ctrl_in;
      s1_down <= down_in;
      s1_col0 <= col0_in;
    end
    // window slides one column per item: mid = above[c], left = above[c-1]
    if (s1_adv) begin
      win_left <= s1.first_col ? s1_col0 : win_mid;
      win_mid  <= rd_data_a;
    end
    if (s1_adv && s1.emit) begin
      neighbour_sum <= sum;
      out_row       <= s1.row;
      out_col       <= s1.col;
      frame_last    <= s1.last;
    end
  end

endmodule

### rtl/four_neighbour_sum_stencil.sv
// ----------------------------------------------------------------------------
// four_neighbour_sum_stencil
// Streaming up/down/left/right neighbour sum over a raster frame, zero border.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): mode 0 carries one pixel in raster order,
// mode 1 is a flush tick. Pixel (r, c) yields the sum for position (r-1, c);
// the first row yields nothing. After the last pixel of a frame, one flush
// tick per column yields the last row, and its final column sets frame_last.
// Pixels sent while a flush is pending and flush ticks with none pending are
// taken and dropped.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 frame_rows,
// index 1 frame_cols, each saturated to 2..MAX. Write only while idle.
// Throughput: one item per cycle while in_stall is low. The item that causes a
// result is registered into the sum stage together with the line store read,
// and the four-term add is registered into the output.
// A stalled result holds; one more item is taken into the sum stage, then
// in_stall rises until the output drains.
// Reset clears the counters and sets a 2x2 frame. The line store is not
// cleared: every entry is written before its data is used in a sum.
// ----------------------------------------------------------------------------
module four_neighbour_sum_stencil #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel / flush items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic signed [PIXEL_BITS-1:0]     pixel,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [PIXEL_BITS+1:0]     neighbour_sum,
  output logic [fnss_pkg::POS_W-1:0]       out_row,
  output logic [fnss_pkg::POS_W-1:0]       out_col,
  output logic                             frame_last,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fnss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fnss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fnss_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);

  logic              accept;
  logic              hold;
  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_slot;
  logic [COL_W-1:0]  mem_wr_col;
  logic              mem_rd_en;
  logic [SLOT_W-1:0] rd_slot_a;
  logic [COL_W-1:0]  rd_col_a;
  logic [SLOT_W-1:0] rd_slot_b;
  logic [COL_W-1:0]  rd_col_b;
  logic [PIXEL_BITS-1:0] rd_data_a;
  logic [PIXEL_BITS-1:0] rd_data_b;
  logic              s1_load;
  s1_ctrl_t          s1_ctrl;
  logic [PIXEL_BITS-1:0] col0_pix;

  // registers accept at any time; software writes only while idle
  assign cfg_ready = 1'b1;
  // the sum stage is the only place an item can wait
  assign in_stall  = hold;
  assign accept    = in_valid && !in_stall;

  fnss_seq #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .mode       (mode),
    .pixel      (pixel),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_slot(mem_wr_slot),
    .mem_wr_col (mem_wr_col),
    .mem_rd_en  (mem_rd_en),
    .rd_slot_a  (rd_slot_a),
    .rd_col_a   (rd_col_a),
    .rd_slot_b  (rd_slot_b),
    .rd_col_b   (rd_col_b),
    .s1_load    (s1_load),
    .s1_ctrl    (s1_ctrl),
    .col0_pix   (col0_pix)
  );

  // Writes go to the row being received, reads to the two rows above it, so
  // a read never meets a write to the same entry in one cycle. A row is read
  // only in the rows after it is written, so no forwarding is needed.
  fnss_line_store #(
    .MAX_COLS  (MAX_COLS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_slot  (mem_wr_slot),
    .wr_col   (mem_wr_col),
    .wr_data  (pixel),
    .rd_en    (mem_rd_en),
    .rd_slot_a(rd_slot_a),
    .rd_col_a (rd_col_a),
    .rd_slot_b(rd_slot_b),
    .rd_col_b (rd_col_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  // pixel delayed with the read gives the neighbour below
  fnss_win #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_win (
    .clk          (clk),
    .rst          (rst),
    .s1_load      (s1_load),
    .s1_ctrl_in   (s1_ctrl),
    .down_in      (pixel),
    .col0_in      (col0_pix),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .out_stall    (out_stall),
    .hold         (hold),
    .out_valid    (out_valid),
    .neighbour_sum(neighbour_sum),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_last   (frame_last)
  );

endmodule

### rtl/fnss_checker.sv
// ----------------------------------------------------------------------------
// fnss_checker
// Port-level checks of the stencil's output timing and stall behavior.
// ----------------------------------------------------------------------------
module fnss_checker #(
  parameter int PIXEL_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [PIXEL_BITS+1:0]  neighbour_sum,
  input logic [9:0]                    out_row,
  input logic [9:0]                    out_col,
  input logic                          frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(neighbour_sum) && $stable(out_row) &&
                               $stable(out_col) && $stable(frame_last))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result is always preceded by the taking of the item that caused it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an item taken two cycles earlier");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind four_neighbour_sum_stencil fnss_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_fnss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .neighbour_sum(neighbour_sum),
  .out_row      (out_row),
  .out_col      (out_col),
  .frame_last   (frame_last)
);

### bench/tb_four_neighbour_sum_stencil.sv
// ----------------------------------------------------------------------------
// tb_four_neighbour_sum_stencil
// Self-checking bench for the streaming four-neighbour sum over a raster frame.
// A cycle-free model of the line store predicts every sum at input acceptance;
// results are compared field by field in order. Directed border and extreme
// cases run first, then register saturation, then random frames with random
// idle gaps and output stalls on both channels, and last a full-rate stream.
// ----------------------------------------------------------------------------
module tb_four_neighbour_sum_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int PIX_W    = 16;
  localparam int SUM_W    = PIX_W + 2;
  localparam int POS_W    = fnss_pkg::POS_W;
  localparam int IDX_W    = fnss_pkg::CFG_IDX_W;
  localparam int DATA_W   = fnss_pkg::CFG_DATA_W;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

  // indexes past the register list; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int RANDOM_ITEMS   = 800;
  localparam int STREAM_ITEMS   = 200;
  // settling margin after the pipeline drains, waited before any register write
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 50;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
  } stencil_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = fnss_pkg::MODE_PIXEL;
  logic signed [PIX_W-1:0]  pixel = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SUM_W-1:0]  neighbour_sum;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic                     frame_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  four_neighbour_sum_stencil #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .PIXEL_BITS(PIX_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .neighbour_sum(neighbour_sum),
    .out_row      (out_row),
    .out_col      (out_col),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line-store model: three row slots, the slot of the incoming row rotates
  // at each row end. Sums of row r-1 are formed as row r arrives; flush ticks
  // produce the final row from the two rows still held.
  // --------------------------------------------------------------------------
  logic signed [PIX_W-1:0] line_pix [0:3*MAX_COLS-1];
  int unsigned slot_base;
  int unsigned next_row;
  int unsigned next_col;
  bit          flush_pending;
  int unsigned flush_pos;
  int unsigned cfg_rows;
  int unsigned cfg_cols;

  stencil_result_t expected_sums [$];
  int error_count = 0;
  bit idle_enable = 1'b1;     // cleared for stretches of full-rate traffic
  int stall_left  = 0;
  int quiet_cycles = 0;

  function automatic void reset_line_model();
    slot_base     = 0;
    next_row      = 0;
    next_col      = 0;
    flush_pending = 1'b0;
    flush_pos     = 0;
    cfg_rows      = fnss_pkg::FRAME_DIM_MIN;
    cfg_cols      = fnss_pkg::FRAME_DIM_MIN;
  endfunction

  // both registers saturate to 2..MAX; spare indexes are dropped
  function automatic int unsigned clamp_dim(input logic [DATA_W-1:0] value, input int hi);
    if (value < fnss_pkg::FRAME_DIM_MIN) return fnss_pkg::FRAME_DIM_MIN;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic void write_frame_reg(input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] value);
    if (idx == fnss_pkg::REG_FRAME_ROWS) cfg_rows = clamp_dim(value, MAX_ROWS);
    else if (idx == fnss_pkg::REG_FRAME_COLS) cfg_cols = clamp_dim(value, MAX_COLS);
  endfunction

  function automatic void predict_neighbour_sum(input logic m,
                                                input logic signed [PIX_W-1:0] p);
    int unsigned cur_s;
    int unsigned prev_s;
    int unsigned prev2_s;
    int unsigned r;
    int unsigned c;
    int acc;
    stencil_result_t res;
    cur_s   = slot_base;
    prev_s  = (cur_s + 2) % 3;
    prev2_s = (cur_s + 1) % 3;
    if (m == fnss_pkg::MODE_FLUSH) begin
      // flush tick with nothing pending is dropped
      if (!flush_pending) return;
      c = flush_pos;
      acc = line_pix[prev2_s*MAX_COLS + c];
      if (c > 0) acc += line_pix[prev_s*MAX_COLS + c - 1];
      if (c + 1 < cfg_cols) acc += line_pix[prev_s*MAX_COLS + c + 1];
      res.sum  = acc[SUM_W-1:0];
      res.row  = POS_W'(cfg_rows - 1);
      res.col  = POS_W'(c);
      res.last = (c + 1 >= cfg_cols);
      expected_sums.push_back(res);
      if (res.last) begin
        flush_pending = 1'b0;
        flush_pos     = 0;
      end else begin
        flush_pos = c + 1;
      end
    end else begin
      // pixel while the last row waits for flushing is dropped
      if (flush_pending) return;
      r = next_row;
      c = next_col;
      line_pix[cur_s*MAX_COLS + c] = p;
      if (r >= 1) begin
        acc = p;
        if (c > 0) acc += line_pix[prev_s*MAX_COLS + c - 1];
        if (c + 1 < cfg_cols) acc += line_pix[prev_s*MAX_COLS + c + 1];
        if (r >= 2) acc += line_pix[prev2_s*MAX_COLS + c];
        res.sum  = acc[SUM_W-1:0];
        res.row  = POS_W'(r - 1);
        res.col  = POS_W'(c);
        res.last = 1'b0;
        expected_sums.push_back(res);
      end
      if (c + 1 >= cfg_cols) begin
        next_col  = 0;
        slot_base = (cur_s + 1) % 3;
        if (r + 1 >= cfg_rows) begin
          next_row      = 0;
          flush_pending = 1'b1;
          flush_pos     = 0;
        end else begin
          next_row = r + 1;
        end
      end else begin
        next_col = c + 1;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result();
    stencil_result_t want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("unexpected result sum=%0d row=%0d col=%0d last=%0b",
                                neighbour_sum, out_row, out_col, frame_last));
      return;
    end
    want = expected_sums.pop_front();
    if (neighbour_sum !== want.sum)
      report_mismatch($sformatf("(%0d,%0d) neighbour_sum %0d, want %0d",
                                want.row, want.col, neighbour_sum, want.sum));
    if (out_row !== want.row)
      report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
    if (out_col !== want.col)
      report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
    if (frame_last !== want.last)
      report_mismatch($sformatf("(%0d,%0d) frame_last %0b, want %0b",
                                want.row, want.col, frame_last, want.last));
  endtask

  // All handshakes sampled here with pre-edge values. The item is predicted
  // before the output is checked so the ordering never depends on latency.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) write_frame_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_neighbour_sum(mode, pixel);
      if (out_valid && !out_stall) check_result();
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 2);
    if (roll < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Output side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (idle_enable && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  // pixels lean toward the rails so the sum hits its extremes now and then
  function automatic logic signed [PIX_W-1:0] pick_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return PIX_MAX;
    if (roll < 16) return PIX_MIN;
    return PIX_W'($urandom);
  endfunction

  // Sends one item and returns at the edge that takes it. Valid stays high
  // afterwards; the next call or wait_idle decides what follows.
  task automatic send_item(input logic m, input logic signed [PIX_W-1:0] p);
    int gap;
    gap = (idle_enable && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pause: drop valid, let every pending sum arrive, then let the
  // pipeline settle in case a dropped item is still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int rows, input int cols);
    wait_idle();
    write_reg(fnss_pkg::REG_FRAME_ROWS, DATA_W'(rows));
    write_reg(fnss_pkg::REG_FRAME_COLS, DATA_W'(cols));
  endtask

  // One whole frame plus its flush ticks. With noise on, stray flush ticks
  // land mid-frame and stray pixels land in the flush phase; both are dropped.
  task automatic stream_frame(input int rows, input int cols, input bit with_noise);
    for (int i = 0; i < rows*cols; i++) begin
      if (with_noise && $urandom_range(0, 99) < 4)
        send_item(fnss_pkg::MODE_FLUSH, pick_pixel());
      send_item(fnss_pkg::MODE_PIXEL, pick_pixel());
    end
    for (int c = 0; c < cols; c++) begin
      if (with_noise && $urandom_range(0, 99) < 4)
        send_item(fnss_pkg::MODE_PIXEL, pick_pixel());
      send_item(fnss_pkg::MODE_FLUSH, pick_pixel());
    end
  endtask

  // Reset geometry (2x2, the two-row case), dropped items on both sides,
  // then 3x3 frames whose centre sees four rail-valued neighbours.
  task automatic test_directed_borders();
    send_item(fnss_pkg::MODE_FLUSH, PIX_MAX);     // nothing pending yet
    send_item(fnss_pkg::MODE_PIXEL, PIX_MAX);
    send_item(fnss_pkg::MODE_PIXEL, PIX_MIN);
    send_item(fnss_pkg::MODE_PIXEL, PIX_MIN);
    send_item(fnss_pkg::MODE_PIXEL, PIX_MAX);
    send_item(fnss_pkg::MODE_PIXEL, 16'sh1234);   // flush pending: dropped
    send_item(fnss_pkg::MODE_FLUSH, '0);
    send_item(fnss_pkg::MODE_FLUSH, '0);
    send_item(fnss_pkg::MODE_FLUSH, '0);          // frame done: dropped
    set_frame(3, 3);
    // edge-centre pixels on the positive rail, corners and centre negative
    for (int i = 0; i < 9; i++)
      send_item(fnss_pkg::MODE_PIXEL, (i % 2) ? PIX_MAX : PIX_MIN);
    repeat (3) send_item(fnss_pkg::MODE_FLUSH, '0);
    // mirrored, so the centre reaches the most negative sum
    for (int i = 0; i < 9; i++)
      send_item(fnss_pkg::MODE_PIXEL, (i % 2) ? PIX_MIN : PIX_MAX);
    repeat (3) send_item(fnss_pkg::MODE_FLUSH, '0);
  endtask

  // Out-of-range writes saturate; spare indexes are no-ops. After each top
  // clamp a few rows or columns run under the wide bound, then a smaller
  // bound is written between items to close the frame early.
  task automatic test_register_saturation();
    wait_idle();
    write_reg(fnss_pkg::REG_FRAME_ROWS, '0);
    write_reg(fnss_pkg::REG_FRAME_COLS, 11'd1);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    stream_frame(2, 2, 1'b0);
    wait_idle();
    write_reg(fnss_pkg::REG_FRAME_ROWS, '1);      // saturates to MAX_ROWS
    write_reg(fnss_pkg::REG_FRAME_COLS, '0);
    for (int i = 0; i < 8; i++)                   // rows 0..3 stay open
      send_item(fnss_pkg::MODE_PIXEL, pick_pixel());
    wait_idle();
    write_reg(fnss_pkg::REG_FRAME_ROWS, 11'd5);   // row 4 closes the frame
    stream_frame(1, 2, 1'b0);
    wait_idle();
    write_reg(fnss_pkg::REG_FRAME_ROWS, 11'd1);
    write_reg(fnss_pkg::REG_FRAME_COLS, 11'd1025); // saturates to MAX_COLS
    for (int i = 0; i < 6; i++)                   // row 0 stays open
      send_item(fnss_pkg::MODE_PIXEL, pick_pixel());
    wait_idle();
    write_reg(fnss_pkg::REG_FRAME_COLS, 11'd7);   // column 6 closes row 0
    send_item(fnss_pkg::MODE_PIXEL, pick_pixel());
    stream_frame(1, 7, 1'b0);
  endtask

  // Random small frames; geometry changes only at frame boundaries after
  // a full drain, otherwise frames follow back to back.
  task automatic test_random_frames();
    int sent;
    int rows;
    int cols;
    sent = 0;
    rows = 2;
    cols = 2;
    idle_enable = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0 || $urandom_range(0, 99) < 40) begin
        rows = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 6) : $urandom_range(2, 12);
        cols = ($urandom_range(0, 99) < 70) ? $urandom_range(2, 8) : $urandom_range(2, 20);
        set_frame(rows, cols);
      end
      stream_frame(rows, cols, 1'b1);
      sent += rows*cols + cols;
    end
  endtask

  // Full rate on both sides: no input gaps, no output stalls.
  task automatic test_no_idle_stream();
    int sent;
    int rows;
    int cols;
    sent = 0;
    rows = $urandom_range(3, 5);
    cols = $urandom_range(4, 9);
    set_frame(rows, cols);
    idle_enable = 1'b0;
    while (sent < STREAM_ITEMS) begin
      stream_frame(rows, cols, 1'b0);
      sent += rows*cols + cols;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    reset_line_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_borders();
    test_register_saturation();
    test_random_frames();
    test_no_idle_stream();
    wait_idle();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/fnss_pkg.sv
rtl/fnss_line_store.sv
rtl/fnss_seq.sv
rtl/fnss_win.sv
rtl/four_neighbour_sum_stencil.sv
rtl/fnss_checker.sv
bench/tb_four_neighbour_sum_stencil.sv
